// ===== design/prfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfc_pkg: shared types and constants for the page replacement fault counter
// Register indexes, policy codes and the control and status bundles that pass
// between the top level and the frame table.
// ----------------------------------------------------------------------------
package prfc_pkg;

    // APB address width: two 32-bit registers at byte addresses 0 and 4
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Register indexes (taken from paddr[2])
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_FRAMES = 1'b1;

    // Replacement policy codes
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    // Width of the frame count register
    localparam int FRAMES_W = 4;

    // Reset value of the frame count register
    localparam logic [FRAMES_W-1:0] FRAMES_RESET = 4'd3;

    // Control bundle from the pipeline into the frame table
    typedef struct packed {
        logic step;        // process the word held in the input register
        logic policy;      // replacement policy code
        logic last;        // word ends the string: clear after it
    } t_frame_ctrl;

    // Status bundle from the frame table back to the pipeline
    typedef struct packed {
        logic hit;         // page already resident
        logic evict;       // a resident page made room for this one
    } t_frame_status;

endpackage

// ===== design/prfc_frames.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfc_frames: frame table with age ranks and fault counter
// Holds the resident pages, their age ranks (0 newest) and the string's
// fault count; looks up one page a cycle while stepped, updating everything in place.
// ----------------------------------------------------------------------------
module prfc_frames #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  prfc_pkg::t_frame_ctrl         i_ctrl,
    input  logic [prfc_pkg::FRAMES_W-1:0] i_frame_count,
    input  logic [PAGE_BITS-1:0]          i_page,
    output prfc_pkg::t_frame_status       o_status,
    output logic [PAGE_BITS-1:0]          o_evict_page,
    output logic [31:0]                   o_fault_total
);

    localparam int RANK_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int LIM_W  = (CNT_W > prfc_pkg::FRAMES_W) ? CNT_W : prfc_pkg::FRAMES_W;

    // State: pages need no reset, a slot counts only below the resident count
    logic [PAGE_BITS-1:0] r_pages [MAX_FRAMES];
    logic [RANK_W-1:0]    r_rank  [MAX_FRAMES];
    logic [RANK_W-1:0]    n_rank  [MAX_FRAMES];
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [31:0]          r_faults;
    logic [31:0]          n_faults;

    logic [MAX_FRAMES-1:0] slot_valid;
    logic [MAX_FRAMES-1:0] slot_match;
    logic [MAX_FRAMES-1:0] slot_hit;
    logic [MAX_FRAMES-1:0] slot_oldest;
    logic [MAX_FRAMES-1:0] slot_free;
    logic [MAX_FRAMES-1:0] slot_load;
    logic                  found;
    logic                  hit;
    logic                  room;
    logic                  lru;
    logic [RANK_W-1:0]     hit_rank;
    logic [LIM_W-1:0]      limit;
    logic [LIM_W-1:0]      count_ext;
    logic [PAGE_BITS-1:0]  evict_page;
    logic [31:0]           faults_inc;

    // Effective frame count: zero acts as one, clamp at the table depth
    always_comb begin
        if (i_frame_count == '0) begin
            limit = LIM_W'(1);
        end else if (LIM_W'(i_frame_count) > LIM_W'(MAX_FRAMES)) begin
            limit = LIM_W'(MAX_FRAMES);
        end else begin
            limit = LIM_W'(i_frame_count);
        end
        count_ext = LIM_W'(r_count);
        room      = count_ext < limit;
    end

    // Compare every resident slot and find the oldest and the next free one
    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            slot_valid[i]  = CNT_W'(i) < r_count;
            slot_match[i]  = slot_valid[i] && (r_pages[i] == i_page);
            slot_oldest[i] = slot_valid[i] && (CNT_W'(r_rank[i]) == r_count - CNT_W'(1));
            slot_free[i]   = CNT_W'(i) == r_count;
        end
    end

    // Keep the first matching slot only; pick its rank and the victim page
    always_comb begin
        found      = 1'b0;
        slot_hit   = '0;
        hit_rank   = '0;
        evict_page = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (slot_match[i] && !found) begin
                slot_hit[i] = 1'b1;
                hit_rank    = r_rank[i];
                found       = 1'b1;
            end
            if (slot_oldest[i]) begin
                evict_page = evict_page | r_pages[i];
            end
        end
        hit = found;
        lru = i_ctrl.policy == prfc_pkg::POLICY_LRU;
    end

    // Work out the next ranks, the slot to load and the counts
    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            n_rank[i]    = r_rank[i];
            slot_load[i] = 1'b0;
            if (hit) begin
                if (lru) begin
                    if (slot_hit[i]) begin
                        n_rank[i] = '0;
                    end else if (slot_valid[i] && r_rank[i] < hit_rank) begin
                        n_rank[i] = r_rank[i] + RANK_W'(1);
                    end
                end
            end else if (room) begin
                if (slot_free[i]) begin
                    n_rank[i]    = '0;
                    slot_load[i] = 1'b1;
                end else if (slot_valid[i]) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end else begin
                if (slot_oldest[i]) begin
                    n_rank[i]    = '0;
                    slot_load[i] = 1'b1;
                end else if (slot_valid[i]) begin
                    n_rank[i] = r_rank[i] + RANK_W'(1);
                end
            end
        end
        n_count    = (!hit && room) ? r_count + CNT_W'(1) : r_count;
        faults_inc = (r_faults == '1) ? r_faults : r_faults + 32'd1;
        n_faults   = hit ? r_faults : faults_inc;
    end

    // Update the table on a step; clear after the last word of a string
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_faults <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_ctrl.step) begin
            if (i_ctrl.last) begin
                r_count  <= '0;
                r_faults <= '0;
                for (int i = 0; i < MAX_FRAMES; i++) begin
                    r_rank[i] <= '0;
                end
            end else begin
                r_count  <= n_count;
                r_faults <= n_faults;
                for (int i = 0; i < MAX_FRAMES; i++) begin
                    r_rank[i] <= n_rank[i];
                end
            end
        end
    end

    // Load the new page into its slot
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (i_ctrl.step && slot_load[i]) begin
                r_pages[i] <= i_page;
            end
        end
    end

    // Result of this lookup, fault count including this word
    always_comb begin
        o_status.hit   = hit;
        o_status.evict = !hit && !room;
        o_evict_page   = o_status.evict ? evict_page : '0;
        o_fault_total  = n_faults;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_FRAMES))
        else $error("resident count above table depth");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.step && i_ctrl.last |=> r_count == '0 && r_faults == '0)
        else $error("string state not cleared after last word");

    a_hit_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.step && !i_ctrl.last && hit |=> r_count == $past(r_count))
        else $error("hit changed the resident count");

    a_single_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.step && o_status.evict |-> $onehot(slot_oldest))
        else $error("eviction without exactly one oldest slot");
`endif

endmodule

// ===== design/page_replacement_fault_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_replacement_fault_counter: FIFO / LRU page replacement with fault count
// Takes one page reference per word, keeps the resident frames in age order
// and reports hit or fault, any eviction and the running fault total.
// ----------------------------------------------------------------------------
//  channel   | direction | fields (low bit first)
//  s_axis    | in        | tdata: page_number; tlast: final_reference
//  m_axis    | out       | tuser: hit, page_fault; tdata: evicted_valid,
//            |           |   evicted_page, fault_total; tlast: string_done
//  apb       | in/out    | 0x0 policy_mode, 0x4 frame_count
//
// One word a cycle while the result side does not stall: a word is held in the
// input register, then the lookup and table update run combinationally and the
// result is registered, so a result passes the input register and the result
// register before it leaves.
// A stalled output holds the result and the input register; the next word
// is still taken while the held result waits if the input register is free.
// Synchronous active-low reset clears the table, counts and registers.
// ----------------------------------------------------------------------------
module page_replacement_fault_counter #(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [((PAGE_BITS+7)/8)*8-1:0] s_axis_tdata,  // page_number
    input  logic                          s_axis_tlast,   // final_reference
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // evicted_valid, evicted_page, fault_total
    output logic [((PAGE_BITS+40)/8)*8-1:0] m_axis_tdata,
    output logic [1:0]                    m_axis_tuser,   // hit, page_fault
    output logic                          m_axis_tlast,   // string_done
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prfc_pkg::ADDR_W-1:0]   paddr,
    input  logic [prfc_pkg::DATA_W-1:0]   pwdata,
    output logic [prfc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int OUT_W = ((PAGE_BITS + 40) / 8) * 8;
    localparam int PAY_W = 1 + PAGE_BITS + 32;

    logic                            r_policy;
    logic [prfc_pkg::FRAMES_W-1:0]   r_frames;
    logic                            r_in_valid;
    logic [PAGE_BITS-1:0]            r_in_page;
    logic                            r_in_last;
    logic                            r_out_valid;
    logic [1:0]                      r_out_user;
    logic [PAY_W-1:0]                r_out_data;
    logic                            r_out_last;

    logic                            cfg_write;
    logic                            advance;
    prfc_pkg::t_frame_ctrl           ctrl;
    prfc_pkg::t_frame_status         status;
    logic [PAGE_BITS-1:0]            evict_page;
    logic [31:0]                     fault_total;

    // Register writes complete in the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= prfc_pkg::POLICY_FIFO;
            r_frames <= prfc_pkg::FRAMES_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                prfc_pkg::REG_POLICY: r_policy <= pwdata[0];
                prfc_pkg::REG_FRAMES: r_frames <= pwdata[prfc_pkg::FRAMES_W-1:0];
                default:              r_policy <= r_policy;
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        unique case (paddr[2])
            prfc_pkg::REG_POLICY: prdata = prfc_pkg::DATA_W'(r_policy);
            prfc_pkg::REG_FRAMES: prdata = prfc_pkg::DATA_W'(r_frames);
            default:              prdata = '0;
        endcase
    end

    // Advance when the result register is empty or being drained
    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    // Hold the incoming word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_page <= s_axis_tdata[PAGE_BITS-1:0];
            r_in_last <= s_axis_tlast;
        end
    end

    // Frame table lookup and update
    assign ctrl.step   = r_in_valid && advance;
    assign ctrl.policy = r_policy;
    assign ctrl.last   = r_in_last;

    prfc_frames #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_frames (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_frame_count (r_frames),
        .i_page        (r_in_page),
        .o_status      (status),
        .o_evict_page  (evict_page),
        .o_fault_total (fault_total)
    );

    // Capture the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.step) begin
            r_out_user <= {!status.hit, status.hit};
            r_out_data <= {fault_total, evict_page, status.evict};
            r_out_last <= r_in_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tdata  = OUT_W'(r_out_data);
    assign m_axis_tlast  = r_out_last;

`ifndef ASSERT_OFF
    a_result_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.step |=> r_out_valid)
        else $error("processed word produced no result");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_user[0] != r_out_user[1]) && !(r_out_user[0] && r_out_data[0]))
        else $error("result flags inconsistent");

    a_no_step_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |-> !ctrl.step)
        else $error("table updated while result stalled");
`endif

endmodule

// ===== test/prfc_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prfc_result_checker: result predictor and scoreboard for the fault counter
// Watches the reference stream, the result stream and the register port. It
// keeps its own frame table, age ranks and fault count, works out the result
// of every accepted page reference and compares each result word, field by
// field, with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module prfc_result_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // reference stream
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [15:0]                   i_in_page,
    input  logic                          i_in_last,
    // result stream
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [55:0]                   i_out_data,
    input  logic [1:0]                    i_out_user,
    input  logic                          i_out_last,
    // register port
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [prfc_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [prfc_pkg::DATA_W-1:0]   i_pwdata,
    // status for the stimulus side
    output int                            o_pending,
    output int                            o_fail_count,
    output int                            o_hits,
    output int                            o_evictions,
    output int                            o_strings
);

    localparam int FRAME_SLOTS = 8;

    typedef struct {
        logic        hit;
        logic        page_fault;
        logic        evicted_valid;
        logic [15:0] evicted_page;
        logic [31:0] fault_total;
        logic        string_done;
    } t_outcome;

    // register mirror
    logic                          policy_sel;
    logic [prfc_pkg::FRAMES_W-1:0] frames_cfg;

    // frame table mirror
    logic [15:0] resident_page [FRAME_SLOTS];
    logic [2:0]  age_rank [FRAME_SLOTS];
    logic [3:0]  resident_total;
    logic [31:0] faults_so_far;

    t_outcome    expected_outcomes [$];
    int          mismatches;
    int          hit_seen;
    int          evict_seen;
    int          strings_seen;

    // End of a string: empty the frames and restart the count
    task automatic clear_string();
        int i;
        for (i = 0; i < FRAME_SLOTS; i++) begin
            age_rank[i] = '0;
        end
        resident_total = '0;
        faults_so_far  = '0;
    endtask

    // Age every resident slot whose rank lies below the limit
    task automatic age_ranks_below(input int limit);
        int i;
        for (i = 0; i < resident_total; i++) begin
            if (age_rank[i] < limit) begin
                age_rank[i] = age_rank[i] + 3'd1;
            end
        end
    endtask

    // Work out the result of one page reference and update the table
    task automatic resolve_reference(input logic [15:0] page, input logic last);
        int       i;
        int       limit;
        int       slot;
        int       oldest;
        bit       found;
        t_outcome res;
        if (frames_cfg == 0) begin
            limit = 1;
        end else if (frames_cfg > FRAME_SLOTS) begin
            limit = FRAME_SLOTS;
        end else begin
            limit = int'(frames_cfg);
        end
        found = 1'b0;
        slot  = 0;
        for (i = 0; i < resident_total; i++) begin
            if (!found && resident_page[i] == page) begin
                found = 1'b1;
                slot  = i;
            end
        end
        res.hit           = found;
        res.page_fault    = !found;
        res.evicted_valid = 1'b0;
        res.evicted_page  = '0;
        res.string_done   = last;
        if (found) begin
            // only the recency order moves, and only under LRU
            if (policy_sel == prfc_pkg::POLICY_LRU) begin
                age_ranks_below(int'(age_rank[slot]));
                age_rank[slot] = '0;
            end
        end else begin
            if (resident_total < limit) begin
                age_ranks_below(FRAME_SLOTS);
                resident_page[resident_total] = page;
                age_rank[resident_total]      = '0;
                resident_total                = resident_total + 4'd1;
            end else begin
                // full (or count lowered): replace the oldest slot
                oldest = 0;
                for (i = 0; i < resident_total; i++) begin
                    if (age_rank[i] > age_rank[oldest]) begin
                        oldest = i;
                    end
                end
                res.evicted_valid = 1'b1;
                res.evicted_page  = resident_page[oldest];
                age_ranks_below(FRAME_SLOTS);
                resident_page[oldest] = page;
                age_rank[oldest]      = '0;
            end
            if (faults_so_far != '1) begin
                faults_so_far = faults_so_far + 32'd1;
            end
        end
        res.fault_total = faults_so_far;
        expected_outcomes.push_back(res);
        if (last) begin
            clear_string();
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Track registers, predict on each reference, compare on each result
    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            policy_sel = prfc_pkg::POLICY_FIFO;
            frames_cfg = prfc_pkg::FRAMES_RESET;
            clear_string();
            expected_outcomes.delete();
            mismatches   = 0;
            hit_seen     = 0;
            evict_seen   = 0;
            strings_seen = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                resolve_reference(i_in_page, i_in_last);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_outcomes.size() == 0) begin
                    $error("result word arrived with no reference outstanding");
                    mismatches++;
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("hit", 32'(want.hit), 32'(i_out_user[0]));
                    check_field("page_fault", 32'(want.page_fault), 32'(i_out_user[1]));
                    check_field("evicted_valid", 32'(want.evicted_valid),
                                32'(i_out_data[0]));
                    check_field("evicted_page", 32'(want.evicted_page),
                                32'(i_out_data[16:1]));
                    check_field("fault_total", want.fault_total, i_out_data[48:17]);
                    check_field("tdata padding", 32'd0, 32'(i_out_data[55:49]));
                    check_field("string_done", 32'(want.string_done), 32'(i_out_last));
                    hit_seen     += int'(want.hit);
                    evict_seen   += int'(want.evicted_valid);
                    strings_seen += int'(want.string_done);
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == prfc_pkg::REG_POLICY) begin
                    policy_sel = i_pwdata[0];
                end else begin
                    frames_cfg = i_pwdata[prfc_pkg::FRAMES_W-1:0];
                end
            end
        end
        o_pending    <= expected_outcomes.size();
        o_fail_count <= mismatches;
        o_hits       <= hit_seen;
        o_evictions  <= evict_seen;
        o_strings    <= strings_seen;
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: page replacement fault counter, FIFO and LRU
// Drives page references with random gaps and a randomly stalling result
// side. A directed opening covers the page extremes, both policies, FIFO and
// LRU hits, evictions, a frame count lowered mid-string and out-of-range frame
// counts; random phases then run strings over small page pools under a range
// of settings. A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 13;
    localparam int REFS_PER_PHASE = 102;
    localparam int FRAME_SLOTS    = 8;

    logic                          i_clk   = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [15:0]                   s_axis_tdata  = '0;     // page_number
    logic                          s_axis_tlast  = 1'b0;   // final_reference
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [55:0]                   m_axis_tdata;  // evicted_valid, evicted_page, fault_total
    logic [1:0]                    m_axis_tuser;           // hit, page_fault
    logic                          m_axis_tlast;           // string_done
    logic                          psel    = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite  = 1'b0;
    logic [prfc_pkg::ADDR_W-1:0]   paddr   = '0;
    logic [prfc_pkg::DATA_W-1:0]   pwdata  = '0;
    logic [prfc_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    int  pending_results;
    int  fail_count;
    int  hit_count;
    int  evict_count;
    int  string_count;
    int  refs_sent;
    int  settings_used;
    int  quiet_cycles;
    bit  burst_run;

    always #2 i_clk = ~i_clk;

    page_replacement_fault_counter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    prfc_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_page    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_out_last   (m_axis_tlast),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_pending    (pending_results),
        .o_fail_count (fail_count),
        .o_hits       (hit_count),
        .o_evictions  (evict_count),
        .o_strings    (string_count)
    );

    // Drop the reference stream and hold until every result word is back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Register write: setup cycle then access cycle; junk above the field
    task automatic write_register(input logic idx,
                                  input logic [prfc_pkg::DATA_W-1:0] value);
        logic [prfc_pkg::DATA_W-1:0] field_mask;
        field_mask = (idx == prfc_pkg::REG_POLICY) ? 32'h1 : 32'hF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom() & ~field_mask) | (value & field_mask);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic policy,
                             input logic [prfc_pkg::FRAMES_W-1:0] frames);
        wait_idle();
        write_register(prfc_pkg::REG_POLICY, {31'd0, policy});
        write_register(prfc_pkg::REG_FRAMES, {28'd0, frames});
        settings_used++;
    endtask

    // Offer one reference word after a random gap and hold until taken
    task automatic send_reference(input logic [15:0] page, input logic last);
        int gap;
        gap = burst_run ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= page;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        refs_sent++;
    endtask

    // Result side: random stall before each word, none in burst phases
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = burst_run ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Watchdog: end the run after a long stretch with no word moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[page_replacement_fault_counter] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [prfc_pkg::FRAMES_W-1:0] phase_frames [RANDOM_PHASES];
        logic [15:0]                   page_pool [FRAME_SLOTS + 2];
        logic [15:0]                   page;
        logic                          last;
        int                            eff_frames;
        int                            pool_size;
        int                            p;
        int                            n;
        int                            k;

        phase_frames = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd8, 4'd4,
                         4'd1, 4'd9, 4'd6, 4'd3, 4'd7, 4'd5};
        refs_sent     = 0;
        settings_used = 0;
        burst_run     = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // FIFO, three frames: extreme pages, a hit that changes nothing, evictions
        configure(prfc_pkg::POLICY_FIFO, 4'd3);
        send_reference(16'h0000, 1'b0);
        send_reference(16'hFFFF, 1'b0);
        send_reference(16'h8000, 1'b0);
        send_reference(16'h0000, 1'b0);
        send_reference(16'h0001, 1'b0);
        send_reference(16'h0000, 1'b0);
        send_reference(16'h1234, 1'b1);

        // LRU, three frames: hits reorder the victims; string left open
        configure(prfc_pkg::POLICY_LRU, 4'd3);
        send_reference(16'h00AA, 1'b0);
        send_reference(16'h00BB, 1'b0);
        send_reference(16'h00CC, 1'b0);
        send_reference(16'h00AA, 1'b0);
        send_reference(16'h00DD, 1'b0);
        send_reference(16'h00CC, 1'b0);
        send_reference(16'h00EE, 1'b0);

        // frame count lowered under a full table
        configure(prfc_pkg::POLICY_LRU, 4'd1);
        send_reference(16'h00FF, 1'b0);
        send_reference(16'h00FF, 1'b0);
        send_reference(16'h0F0F, 1'b1);

        // frame count zero acts as one frame
        configure(prfc_pkg::POLICY_FIFO, 4'd0);
        send_reference(16'h5555, 1'b0);
        send_reference(16'h5555, 1'b0);
        send_reference(16'hAAAA, 1'b1);

        // frame count above the maximum saturates
        configure(prfc_pkg::POLICY_LRU, 4'd15);
        for (k = 1; k <= 9; k++) begin
            send_reference(16'(k), k == 9);
        end

        // random phases: strings over a small page pool, occasional strays
        for (p = 0; p < RANDOM_PHASES; p++) begin
            configure(p[0] ^ p[2], phase_frames[p]);
            burst_run = ($urandom_range(0, 3) == 0);
            if (phase_frames[p] == 0) begin
                eff_frames = 1;
            end else if (phase_frames[p] > FRAME_SLOTS) begin
                eff_frames = FRAME_SLOTS;
            end else begin
                eff_frames = int'(phase_frames[p]);
            end
            pool_size = eff_frames + 2;
            for (k = 0; k < pool_size; k++) begin
                page_pool[k] = 16'($urandom_range(0, 65535));
            end
            for (n = 0; n < REFS_PER_PHASE; n++) begin
                if ($urandom_range(0, 7) == 0) begin
                    page = 16'($urandom_range(0, 65535));
                end else begin
                    page = page_pool[$urandom_range(0, pool_size - 1)];
                end
                last = ($urandom_range(0, 15) == 0);
                send_reference(page, last);
                // fresh pool for the next string
                if (last) begin
                    for (k = 0; k < pool_size; k++) begin
                        page_pool[k] = 16'($urandom_range(0, 65535));
                    end
                end
            end
            burst_run = 1'b0;
        end

        // drain and settle
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results != 0);
        repeat (8) @(posedge i_clk);

        $display("Summary: %0d page references under %0d policy and frame settings",
                 refs_sent, settings_used);
        $display("Summary: %0d hits, %0d evictions, %0d strings closed",
                 hit_count, evict_count, string_count);
        if (fail_count == 0) begin
            $display("[page_replacement_fault_counter] OK");
        end else begin
            $display("[page_replacement_fault_counter] ERROR");
        end
        $finish;
    end

endmodule
